@@ src/lpd_pkg.sv @@
package lpd_pkg;

    localparam int COLOR_W    = 8;
    localparam int X_W        = 9;
    localparam int Y_W        = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FILL_BYTE   = 2'd0;
    localparam t_cfg_idx CFG_MIN_MATCH   = 2'd1;
    localparam t_cfg_idx CFG_WRITE_START = 2'd2;

endpackage

@@ src/lpd_ifs.sv @@
interface lpd_in_if;
    import lpd_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lpd_out_if;
    import lpd_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic               run_end;
    modport source (output valid, output pixel_color, output pixel_x, output pixel_y,
                    output run_end, input ready);
    modport sink   (input valid, input pixel_color, input pixel_x, input pixel_y,
                    input run_end, output ready);
endinterface

interface lpd_cfg_if;
    import lpd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

@@ src/lpd_ram.sv @@
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lzss_pixel_decoder.sv @@
// LZSS pixel decoder: one compressed byte per input transaction, one pixel per output
// transaction with its raster position; run_end marks the last pixel caused by a byte.
// A flag byte or a literal byte is taken in S_IDLE; a reference's second byte starts a
// copy that first reads the history in S_RD and then, while the output is not stalled,
// delivers one pixel per cycle through the single read port of the history RAM, so a
// reference (length up to 18) holds the input from its second byte until the copy ends.
// The window needs no clearing pass at stream start: a count of entries written since the
// stream began marks the rest of the window as holding the fill byte latched at that start.
module lzss_pixel_decoder #(
    parameter int WINDOW_SIZE   = 1024,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpd_in_if.sink    i_in,
    lpd_out_if.source o_out,
    lpd_cfg_if.sink   i_cfg
);
    import lpd_pkg::*;

    localparam int AW = $clog2(WINDOW_SIZE);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    localparam logic [1:0] PH_FLAG   = 2'd0;
    localparam logic [1:0] PH_ITEM   = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;

    // control state
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_flag_bits, n_flag_bits;
    logic [3:0]    r_flags_left, n_flags_left;
    logic [7:0]    r_ref_high, n_ref_high;
    logic [X_W-1:0] r_col, n_col;
    logic [Y_W-1:0] r_row, n_row;
    logic          r_full, n_full;
    logic          r_fresh, n_fresh;
    logic [AW-1:0] r_wpos, n_wpos;
    logic [AW:0]   r_wcnt, n_wcnt;
    logic [AW-1:0] r_ws_lat, n_ws_lat;
    logic [7:0]    r_fill_lat, n_fill_lat;
    logic [7:0]    r_fill_byte;
    logic [1:0]    r_min_match;
    logic [9:0]    r_write_start;
    logic [AW-1:0] r_rp, n_rp;
    logic [4:0]    r_left, n_left;
    logic          r_last_pend, n_last_pend;
    logic          r_fwd, n_fwd;
    logic          r_unw, n_unw;
    logic          r_out_valid, n_out_valid;

    // payload
    logic [7:0]         r_fwd_data, n_fwd_data;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic [X_W-1:0]     r_out_x, n_out_x;
    logic [Y_W-1:0]     r_out_y, n_out_y;
    logic               r_out_end, n_out_end;

    // RAM port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          slot_free, in_acc;
    logic [AW-1:0] cur_wpos;
    logic [AW:0]   cur_wcnt;
    logic          do_emit, emit_end, do_item_done, do_stream_reset;
    logic [7:0]    emit_color, copy_color;
    logic [X_W:0]  col_inc;
    logic [Y_W:0]  row_inc;
    logic          col_wrap, full_now;
    logic [4:0]    ref_len;
    logic [9:0]    ref_offset;
    logic [AW:0]   rd_dist;
    logic          rd_unw;
    logic [AW-1:0] rp_inc;
    logic [4:0]    left_dec;

    lpd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_SIZE)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_wpos),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_free  = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_color = r_out_color;
    assign o_out.pixel_x     = r_out_x;
    assign o_out.pixel_y     = r_out_y;
    assign o_out.run_end     = r_out_end;

    // first byte of a stream relocates the write pointer
    assign cur_wpos = r_fresh ? AW'(r_write_start) : r_wpos;
    assign cur_wcnt = r_fresh ? '0 : r_wcnt;

    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign col_wrap = col_inc >= (X_W+1)'(SCREEN_WIDTH);
    assign full_now = col_wrap && (row_inc >= (Y_W+1)'(SCREEN_HEIGHT));

    assign ref_offset = {r_ref_high[5:0], i_in.data_byte[7:4]};
    assign ref_len    = {1'b0, i_in.data_byte[3:0]} + {3'b000, r_min_match};

    assign rp_inc = (r_rp == AW'(WINDOW_SIZE - 1)) ? '0 : r_rp + 1'b1;

    // distance of the read address past the stream's first write position
    always_comb begin
        if (r_rp >= r_ws_lat) begin
            rd_dist = {1'b0, r_rp} - {1'b0, r_ws_lat};
        end else begin
            rd_dist = {1'b0, r_rp} + (AW+1)'(WINDOW_SIZE) - {1'b0, r_ws_lat};
        end
    end
    assign rd_unw = rd_dist >= r_wcnt;

    assign copy_color = r_fwd ? r_fwd_data : (r_unw ? r_fill_lat : ram_rdata);
    assign left_dec   = r_left - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_flag_bits  = r_flag_bits;
        n_flags_left = r_flags_left;
        n_ref_high   = r_ref_high;
        n_col        = r_col;
        n_row        = r_row;
        n_full       = r_full;
        n_fresh      = r_fresh;
        n_wpos       = r_wpos;
        n_wcnt       = r_wcnt;
        n_ws_lat     = r_ws_lat;
        n_fill_lat   = r_fill_lat;
        n_rp         = r_rp;
        n_left       = r_left;
        n_last_pend  = r_last_pend;
        n_fwd        = r_fwd;
        n_fwd_data   = r_fwd_data;
        n_unw        = r_unw;
        n_out_valid  = r_out_valid;
        n_out_color  = r_out_color;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_end    = r_out_end;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_rp;
        ram_wdata = 8'h00;

        do_emit         = 1'b0;
        emit_end        = 1'b0;
        emit_color      = i_in.data_byte;
        do_item_done    = 1'b0;
        do_stream_reset = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_fresh) begin
                        n_fresh    = 1'b0;
                        n_fill_lat = r_fill_byte;
                        n_ws_lat   = AW'(r_write_start);
                        n_wpos     = AW'(r_write_start);
                        n_wcnt     = '0;
                    end
                    do_stream_reset = i_in.last_byte;
                    if (!r_full) begin
                        case (r_phase)
                            PH_ITEM: begin
                                if (r_flag_bits[0]) begin
                                    do_emit      = 1'b1;
                                    emit_end     = 1'b1;
                                    do_item_done = 1'b1;
                                end else begin
                                    n_ref_high = i_in.data_byte;
                                    n_phase    = PH_SECOND;
                                end
                            end
                            PH_SECOND: begin
                                if (ref_len == '0) begin
                                    do_item_done = 1'b1;
                                end else begin
                                    // defer end-of-stream until the copy finishes
                                    n_rp            = AW'(ref_offset);
                                    n_left          = ref_len;
                                    n_last_pend     = i_in.last_byte;
                                    n_state         = S_RD;
                                    do_stream_reset = 1'b0;
                                end
                            end
                            default: begin
                                n_flag_bits  = i_in.data_byte;
                                n_flags_left = 4'd8;
                                n_phase      = PH_ITEM;
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_rp    = rp_inc;
                n_unw   = rd_unw;
                n_fwd   = 1'b0;
                n_state = S_COPY;
            end
            S_COPY: begin
                if (slot_free) begin
                    do_emit    = 1'b1;
                    emit_color = copy_color;
                    n_left     = left_dec;
                    if ((r_left == 5'd1) || full_now) begin
                        emit_end        = 1'b1;
                        do_item_done    = 1'b1;
                        do_stream_reset = r_last_pend;
                        n_state         = S_IDLE;
                    end else begin
                        // next read; forward the byte being written if it is the target
                        ram_re     = 1'b1;
                        n_rp       = rp_inc;
                        n_unw      = rd_unw;
                        n_fwd      = (r_rp == r_wpos);
                        n_fwd_data = copy_color;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_emit) begin
            ram_we      = 1'b1;
            ram_wdata   = emit_color;
            n_wpos      = (cur_wpos == AW'(WINDOW_SIZE - 1)) ? '0 : cur_wpos + 1'b1;
            n_wcnt      = (cur_wcnt == (AW+1)'(WINDOW_SIZE)) ? cur_wcnt : cur_wcnt + 1'b1;
            n_out_valid = 1'b1;
            n_out_color = emit_color;
            n_out_x     = r_col;
            n_out_y     = r_row;
            n_out_end   = emit_end;
            if (col_wrap) begin
                n_col = '0;
                n_row = row_inc[Y_W-1:0];
                if (full_now) begin
                    n_full = 1'b1;
                end
            end else begin
                n_col = col_inc[X_W-1:0];
            end
        end

        if (do_item_done) begin
            n_flag_bits  = {1'b0, r_flag_bits[7:1]};
            n_flags_left = (r_flags_left != 4'd0) ? r_flags_left - 1'b1 : 4'd0;
            n_phase      = (n_flags_left != 4'd0) ? PH_ITEM : PH_FLAG;
        end

        if (do_stream_reset) begin
            n_flag_bits  = '0;
            n_flags_left = '0;
            n_phase      = PH_FLAG;
            n_ref_high   = '0;
            n_col        = '0;
            n_row        = '0;
            n_full       = 1'b0;
            n_fresh      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_FLAG;
            r_flag_bits   <= '0;
            r_flags_left  <= '0;
            r_ref_high    <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_full        <= 1'b0;
            r_fresh       <= 1'b1;
            r_wpos        <= '0;
            r_wcnt        <= '0;
            r_ws_lat      <= '0;
            r_fill_lat    <= '0;
            r_fill_byte   <= 8'd0;
            r_min_match   <= 2'd2;
            r_write_start <= 10'd1006;
            r_rp          <= '0;
            r_left        <= '0;
            r_last_pend   <= 1'b0;
            r_fwd         <= 1'b0;
            r_unw         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_ref_high   <= n_ref_high;
            r_col        <= n_col;
            r_row        <= n_row;
            r_full       <= n_full;
            r_fresh      <= n_fresh;
            r_wpos       <= n_wpos;
            r_wcnt       <= n_wcnt;
            r_ws_lat     <= n_ws_lat;
            r_fill_lat   <= n_fill_lat;
            r_rp         <= n_rp;
            r_left       <= n_left;
            r_last_pend  <= n_last_pend;
            r_fwd        <= n_fwd;
            r_unw        <= n_unw;
            r_out_valid  <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    CFG_FILL_BYTE:   r_fill_byte   <= i_cfg.wr_data[7:0];
                    CFG_MIN_MATCH:   r_min_match   <= i_cfg.wr_data[1:0];
                    CFG_WRITE_START: r_write_start <= i_cfg.wr_data[9:0];
                    default: begin
                        // unmapped index: drop
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data  <= n_fwd_data;
        r_out_color <= n_out_color;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_end   <= n_out_end;
    end

endmodule

@@ tb/lpd_pixel_check.sv @@
`timescale 1ns / 100ps

module lpd_pixel_check #(
    parameter int WINDOW_SIZE   = 1024,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lpd_in_if    i_in,
    lpd_out_if   i_out,
    lpd_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);
    import lpd_pkg::*;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic               run_end;
    } t_pixel;

    typedef enum logic [1:0] {
        EXPECT_FLAG,
        EXPECT_ITEM,
        EXPECT_SECOND
    } t_parse;

    // register copies
    logic [7:0] fill_byte;
    logic [1:0] min_match;
    logic [9:0] write_start;

    // decoder state
    logic [7:0] window_mem [WINDOW_SIZE];
    int         wr_pos;
    logic [7:0] flag_bits;
    logic [3:0] flags_left;
    t_parse     parse_phase;
    logic [7:0] ref_high;
    int         col;
    int         row;
    logic       screen_full;
    logic       stream_fresh;

    t_pixel     pixels_due[$];
    int         fails;

    task automatic restart_stream();
        flag_bits    = '0;
        flags_left   = '0;
        parse_phase  = EXPECT_FLAG;
        ref_high     = '0;
        col          = 0;
        row          = 0;
        screen_full  = 1'b0;
        stream_fresh = 1'b1;
    endtask

    task automatic put_pixel(input logic [7:0] color);
        t_pixel px;
        px.color   = color;
        px.x       = col[X_W-1:0];
        px.y       = row[Y_W-1:0];
        px.run_end = 1'b0;
        pixels_due.push_back(px);
        window_mem[wr_pos] = color;
        wr_pos = (wr_pos + 1) % WINDOW_SIZE;
        col++;
        if (col >= SCREEN_WIDTH) begin
            col = 0;
            row++;
            if (row >= SCREEN_HEIGHT)
                screen_full = 1'b1;
        end
    endtask

    task automatic finish_item();
        flag_bits = flag_bits >> 1;
        if (flags_left != 0)
            flags_left--;
        parse_phase = (flags_left != 0) ? EXPECT_ITEM : EXPECT_FLAG;
    endtask

    task automatic decode_byte(input logic [7:0] data, input logic last);
        int     base;
        int     offset;
        int     len;
        t_pixel tail;
        base = pixels_due.size();
        // window fill and write position load happen on the first byte of a stream
        if (stream_fresh) begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                window_mem[i] = fill_byte;
            wr_pos = int'(write_start) % WINDOW_SIZE;
            stream_fresh = 1'b0;
        end
        if (!screen_full) begin
            case (parse_phase)
                EXPECT_ITEM: begin
                    if (flag_bits[0]) begin
                        put_pixel(data);
                        finish_item();
                    end else begin
                        ref_high    = data;
                        parse_phase = EXPECT_SECOND;
                    end
                end
                EXPECT_SECOND: begin
                    offset = int'({ref_high[5:0], data[7:4]});
                    len    = int'(data[3:0]) + int'(min_match);
                    // copy byte by byte so an overlapping source repeats
                    for (int j = 0; j < len && !screen_full; j++)
                        put_pixel(window_mem[(offset + j) % WINDOW_SIZE]);
                    finish_item();
                end
                default: begin
                    flag_bits   = data;
                    flags_left  = 4'd8;
                    parse_phase = EXPECT_ITEM;
                end
            endcase
        end
        if (pixels_due.size() > base) begin
            tail = pixels_due.pop_back();
            tail.run_end = 1'b1;
            pixels_due.push_back(tail);
        end
        if (last)
            restart_stream();
    endtask

    task automatic check_pixel();
        t_pixel got;
        t_pixel want;
        got.color   = i_out.pixel_color;
        got.x       = i_out.pixel_x;
        got.y       = i_out.pixel_y;
        got.run_end = i_out.run_end;
        if (pixels_due.size() == 0) begin
            fails++;
            $display("%0t: unexpected pixel: expected none, got color %0d x %0d y %0d end %0d",
                     $time, got.color, got.x, got.y, got.run_end);
        end else begin
            want = pixels_due.pop_front();
            if (got.color !== want.color || got.x !== want.x || got.y !== want.y ||
                got.run_end !== want.run_end) begin
                fails++;
                $display("%0t: pixel mismatch: expected color %0d x %0d y %0d end %0d,",
                         $time, want.color, want.x, want.y, want.run_end);
                $display("    got color %0d x %0d y %0d end %0d",
                         got.color, got.x, got.y, got.run_end);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_byte   = 8'd0;
            min_match   = 2'd2;
            write_start = 10'd1006;
            restart_stream();
            pixels_due.delete();
            fails = 0;
        end else begin
            // compare first: a byte accepted now cannot have produced a pixel yet
            if (i_out.valid && i_out.ready)
                check_pixel();
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.reg_index)
                    CFG_FILL_BYTE:   fill_byte   = i_cfg.wr_data[7:0];
                    CFG_MIN_MATCH:   min_match   = i_cfg.wr_data[1:0];
                    CFG_WRITE_START: write_start = i_cfg.wr_data[9:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                decode_byte(i_in.data_byte, i_in.last_byte);
        end
        o_pending    <= pixels_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ tb/lzss_pixel_decoder_test.sv @@
`timescale 1ns / 100ps

module lzss_pixel_decoder_test;
    import lpd_pkg::*;

    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       SETTLE_CYCLES  = 30;
    localparam int       PHASE_BYTES    = 90;
    localparam t_cfg_idx CFG_UNUSED     = 2'd3;

    logic i_clk;
    logic i_rst_n;
    bit   idle_en;
    int   fail_count;
    int   pending;
    int   stall_cycles;

    lpd_in_if  in_ch ();
    lpd_out_if out_ch ();
    lpd_cfg_if cfg_ch ();

    lzss_pixel_decoder dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    lpd_pixel_check pixel_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // abort when no channel moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= !idle_en || ($urandom_range(99) >= 9);
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.last_byte <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        if (idle_en && $urandom_range(99) < 9) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // hold input until every pixel is out, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] fill, input logic [1:0] mm,
                            input logic [9:0] wstart);
        logic [CFG_DATA_W-1:0] v;
        // randomize the unused upper bits of each write
        v = CFG_DATA_W'($urandom);
        v[7:0] = fill;
        write_reg(CFG_FILL_BYTE, v);
        v = CFG_DATA_W'($urandom);
        v[1:0] = mm;
        write_reg(CFG_MIN_MATCH, v);
        write_reg(CFG_WRITE_START, wstart);
    endtask

    task automatic random_stream(output int sent);
        logic [7:0] bytes[$];
        logic [7:0] flag;
        int         kind;
        int         cut;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) begin
                flag = 8'($urandom);
                bytes.push_back(flag);
                for (int b = 0; b < 8; b++) begin
                    bytes.push_back(8'($urandom));
                    if (!flag[b])
                        bytes.push_back(8'($urandom));
                end
            end
            // truncate some streams at an arbitrary byte
            if (kind < 25) begin
                cut = int'($urandom_range(1, bytes.size()));
                while (bytes.size() > cut) void'(bytes.pop_back());
            end
        end
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
        sent = bytes.size();
    endtask

    task automatic random_phase(input logic [7:0] fill, input logic [1:0] mm,
                                input logic [9:0] wstart);
        int total;
        int sent;
        int streams;
        drain();
        set_regs(fill, mm, wstart);
        total   = 0;
        streams = 0;
        while (total < PHASE_BYTES) begin
            random_stream(sent);
            total += sent;
            streams++;
            if (streams % 8 == 0)
                drain();
        end
    endtask

    initial begin
        idle_en          = 1'b1;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.data_byte  <= '0;
        in_ch.last_byte  <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= CFG_FILL_BYTE;
        cfg_ch.wr_data   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_regs(8'hA5, 2'd0, 10'd1020);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

        // literals, zero-length reference, overlapping copies across the window wrap
        send_byte(8'h85, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hCF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h35, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);

        // lone reference byte at stream end
        send_byte(8'hFE, 1'b0);
        send_byte(8'h12, 1'b1);

        // mid-stream writes: min_match acts at once, the others at next stream
        drain();
        set_regs(8'hFF, 2'd3, 10'd0);
        send_byte(8'h04, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h2F, 1'b0);
        drain();
        write_reg(CFG_MIN_MATCH, 10'd1);
        write_reg(CFG_FILL_BYTE, 10'h03C);
        write_reg(CFG_WRITE_START, 10'h155);
        send_byte(8'h3F, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h15, 1'b0);
        send_byte(8'h53, 1'b1);

        random_phase(8'h00, 2'd0, 10'd0);
        idle_en = 1'b0;
        random_phase(8'hFF, 2'd3, 10'd1023);
        idle_en = 1'b1;
        random_phase(8'($urandom), 2'($urandom), 10'($urandom));
        random_phase(8'($urandom), 2'($urandom), 10'($urandom));

        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
